// ===== rtl/oled_command_decoder_assert.svh =====
// Assertion macros used by the decoder top level.
`ifndef OLED_COMMAND_DECODER_ASSERT_SVH
`define OLED_COMMAND_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OCD_ASSERT_IMP(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("ocd assertion failed");

// Next-cycle implication, checked out of reset.
`define OCD_ASSERT_NXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("ocd assertion failed");

`endif

// ===== rtl/ocd_pkg.sv =====
package ocd_pkg;

    // no-command marker and the opcodes that open a command
    localparam logic [7:0] OP_NONE         = 8'h00;
    localparam logic [7:0] OP_CONTRAST     = 8'h81;
    localparam logic [7:0] OP_SCROLL_R     = 8'h26;
    localparam logic [7:0] OP_SCROLL_L     = 8'h27;
    localparam logic [7:0] OP_VSCROLL_R    = 8'h29;
    localparam logic [7:0] OP_VSCROLL_L    = 8'h2A;
    localparam logic [7:0] OP_VSCROLL_AREA = 8'hA3;
    localparam logic [7:0] OP_ADDR_MODE    = 8'h20;
    localparam logic [7:0] OP_COL_ADDR     = 8'h21;
    localparam logic [7:0] OP_PAGE_ADDR    = 8'h22;
    localparam logic [7:0] OP_MUX_RATIO    = 8'hA8;
    localparam logic [7:0] OP_DISP_OFFSET  = 8'hD3;
    localparam logic [7:0] OP_COM_PINS     = 8'hDA;
    localparam logic [7:0] OP_CLK_DIV      = 8'hD5;
    localparam logic [7:0] OP_PRECHARGE    = 8'hD9;
    localparam logic [7:0] OP_VCOMH        = 8'hDB;
    localparam logic [7:0] OP_CHARGE_PUMP  = 8'h8D;

    // dense register ids
    localparam logic [4:0] REG_CONTRAST     = 5'd0;
    localparam logic [4:0] REG_ENTIRE_ON    = 5'd1;
    localparam logic [4:0] REG_INVERSE      = 5'd2;
    localparam logic [4:0] REG_DISPLAY_ON   = 5'd3;
    localparam logic [4:0] REG_SCROLL_KIND  = 5'd4;
    localparam logic [4:0] REG_SCROLL_START = 5'd5;
    localparam logic [4:0] REG_SCROLL_INTVL = 5'd6;
    localparam logic [4:0] REG_SCROLL_END   = 5'd7;
    localparam logic [4:0] REG_VSCROLL_OFS  = 5'd8;
    localparam logic [4:0] REG_SCROLL_ACT   = 5'd9;
    localparam logic [4:0] REG_FIXED_ROWS   = 5'd10;
    localparam logic [4:0] REG_SCROLL_ROWS  = 5'd11;
    localparam logic [4:0] REG_COL_LO       = 5'd12;
    localparam logic [4:0] REG_COL_HI       = 5'd13;
    localparam logic [4:0] REG_ADDR_MODE    = 5'd14;
    localparam logic [4:0] REG_COL_START    = 5'd15;
    localparam logic [4:0] REG_COL_END      = 5'd16;
    localparam logic [4:0] REG_PAGE_START   = 5'd17;
    localparam logic [4:0] REG_PAGE_END     = 5'd18;
    localparam logic [4:0] REG_PAGE_MODE_PG = 5'd19;
    localparam logic [4:0] REG_START_LINE   = 5'd20;
    localparam logic [4:0] REG_SEG_REMAP    = 5'd21;
    localparam logic [4:0] REG_MUX_RATIO    = 5'd22;
    localparam logic [4:0] REG_COM_SCAN     = 5'd23;
    localparam logic [4:0] REG_DISP_OFFSET  = 5'd24;
    localparam logic [4:0] REG_COM_PINS     = 5'd25;
    localparam logic [4:0] REG_CLK_DIV      = 5'd26;
    localparam logic [4:0] REG_PRECHARGE    = 5'd27;
    localparam logic [4:0] REG_VCOMH        = 5'd28;
    localparam logic [4:0] REG_CHARGE_PUMP  = 5'd29;

    localparam logic [7:0] MUX_MIN = 8'd15;

    typedef struct packed {
        logic [7:0] opcode;
        logic [2:0] pos;
    } ocd_state_t;

    typedef struct packed {
        logic       emit;
        logic       is_data;
        logic [4:0] reg_id;
        logic [7:0] reg_value;
        logic       invalid;
    } ocd_result_t;

    function automatic logic [2:0] arg_count(input logic [7:0] op);
        logic [2:0] n;
        case (op)
            OP_SCROLL_R, OP_SCROLL_L:                  n = 3'd6;
            OP_VSCROLL_R, OP_VSCROLL_L:                n = 3'd5;
            OP_VSCROLL_AREA, OP_COL_ADDR, OP_PAGE_ADDR: n = 3'd2;
            OP_CONTRAST, OP_ADDR_MODE, OP_MUX_RATIO, OP_DISP_OFFSET, OP_COM_PINS,
            OP_CLK_DIV, OP_PRECHARGE, OP_VCOMH, OP_CHARGE_PUMP: n = 3'd1;
            default:                                   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic ocd_result_t mk_result(input logic [4:0] id, input logic [7:0] val,
                                              input logic bad);
        ocd_result_t r;
        r.emit      = 1'b1;
        r.is_data   = 1'b0;
        r.reg_id    = id;
        r.reg_value = val;
        r.invalid   = bad;
        return r;
    endfunction

endpackage

// ===== rtl/ocd_decode.sv =====
module ocd_decode
    import ocd_pkg::*;
(
    input  ocd_state_t  state,
    input  logic        cmd,
    input  logic [7:0]  value,
    output ocd_result_t result,
    output ocd_state_t  state_next
);

    logic [2:0] cnt;
    logic [3:0] pos_inc;
    logic       vscroll;

    assign vscroll = (state.opcode == OP_VSCROLL_R) || (state.opcode == OP_VSCROLL_L);

    always_comb
    begin
        result     = '0;
        state_next = state;
        cnt        = arg_count(state.opcode);
        pos_inc    = {1'b0, state.pos} + 4'd1;
        if (!cmd)
        begin
            // data beat passes through, open command untouched
            result.emit      = 1'b1;
            result.is_data   = 1'b1;
            result.reg_value = value;
        end
        else if (state.opcode != OP_NONE)
        begin
            case (state.opcode)
                OP_CONTRAST: result = mk_result(REG_CONTRAST, value, 1'b0);
                OP_SCROLL_R, OP_SCROLL_L, OP_VSCROLL_R, OP_VSCROLL_L:
                begin
                    // position 0 and the tail are dummy bytes
                    if (state.pos == 3'd1)
                        result = mk_result(REG_SCROLL_START, {5'd0, value[2:0]}, 1'b0);
                    else if (state.pos == 3'd2)
                        result = mk_result(REG_SCROLL_INTVL, {5'd0, value[2:0]}, 1'b0);
                    else if (state.pos == 3'd3)
                        result = mk_result(REG_SCROLL_END, {5'd0, value[2:0]}, 1'b0);
                    else if (state.pos == 3'd4 && vscroll)
                        result = mk_result(REG_VSCROLL_OFS, {2'd0, value[5:0]}, 1'b0);
                end
                OP_VSCROLL_AREA:
                begin
                    if (state.pos == 3'd0)
                        result = mk_result(REG_FIXED_ROWS, {2'd0, value[5:0]}, 1'b0);
                    else
                        result = mk_result(REG_SCROLL_ROWS, {1'b0, value[6:0]}, 1'b0);
                end
                OP_ADDR_MODE:
                    result = mk_result(REG_ADDR_MODE, {6'd0, value[1:0]}, &value[1:0]);
                OP_COL_ADDR:
                    result = mk_result((state.pos == 3'd0) ? REG_COL_START : REG_COL_END,
                                       {1'b0, value[6:0]}, 1'b0);
                OP_PAGE_ADDR:
                    result = mk_result((state.pos == 3'd0) ? REG_PAGE_START : REG_PAGE_END,
                                       {5'd0, value[2:0]}, 1'b0);
                OP_MUX_RATIO:
                    result = mk_result(REG_MUX_RATIO, {2'd0, value[5:0]},
                                       {2'd0, value[5:0]} < MUX_MIN);
                OP_DISP_OFFSET:
                    result = mk_result(REG_DISP_OFFSET, {2'd0, value[5:0]}, 1'b0);
                OP_COM_PINS:
                    result = mk_result(REG_COM_PINS, {2'd0, value[5:4], 4'd0}, 1'b0);
                OP_CLK_DIV:
                    result = mk_result(REG_CLK_DIV, value, 1'b0);
                OP_PRECHARGE:
                    result = mk_result(REG_PRECHARGE, value,
                                       (value[3:0] == 4'd0) || (value[7:4] == 4'd0));
                OP_VCOMH:
                    result = mk_result(REG_VCOMH, {1'b0, value[6:4], 4'd0}, 1'b0);
                OP_CHARGE_PUMP:
                    result = mk_result(REG_CHARGE_PUMP, {5'd0, value[2], 2'd0}, 1'b0);
                default: result = '0;
            endcase
            if (pos_inc >= {1'b0, cnt})
                state_next = '0;
            else
                state_next.pos = pos_inc[2:0];
        end
        else
        begin
            case (value) inside
                [8'h00:8'h0F]: result = mk_result(REG_COL_LO, {4'd0, value[3:0]}, 1'b0);
                [8'h10:8'h1F]: result = mk_result(REG_COL_HI, {4'd0, value[3:0]}, 1'b0);
                [8'h40:8'h7F]: result = mk_result(REG_START_LINE, {2'd0, value[5:0]}, 1'b0);
                [8'hB0:8'hB7]: result = mk_result(REG_PAGE_MODE_PG, {5'd0, value[2:0]}, 1'b0);
                [8'hC0:8'hCF]: result = mk_result(REG_COM_SCAN, {7'd0, value[3]}, 1'b0);
                [8'hA4:8'hA5]: result = mk_result(REG_ENTIRE_ON, {7'd0, value[0]}, 1'b0);
                [8'hA6:8'hA7]: result = mk_result(REG_INVERSE, {7'd0, value[0]}, 1'b0);
                [8'hAE:8'hAF]: result = mk_result(REG_DISPLAY_ON, {7'd0, value[0]}, 1'b0);
                [8'hA0:8'hA1]: result = mk_result(REG_SEG_REMAP, {7'd0, value[0]}, 1'b0);
                [8'h2E:8'h2F]: result = mk_result(REG_SCROLL_ACT, {7'd0, value[0]}, 1'b0);
                OP_SCROLL_R:   result = mk_result(REG_SCROLL_KIND, 8'd0, 1'b0);
                OP_SCROLL_L:   result = mk_result(REG_SCROLL_KIND, 8'd1, 1'b0);
                OP_VSCROLL_R:  result = mk_result(REG_SCROLL_KIND, 8'd2, 1'b0);
                OP_VSCROLL_L:  result = mk_result(REG_SCROLL_KIND, 8'd3, 1'b0);
                default:       result = '0;
            endcase
            if (arg_count(value) != 3'd0)
            begin
                state_next.opcode = value;
                state_next.pos    = 3'd0;
            end
        end
    end

endmodule

// ===== rtl/oled_command_decoder.sv =====
// Command decoder for a 128x64 monochrome panel controller.
// Input stream (s_*): one beat per byte sent after the link control byte;
// s_tuser is 1 for a command byte, 0 for a display data byte.
// Output stream (m_*): one beat per byte that writes a register or is
// display data. Argument bytes of open commands are tracked internally;
// dummy arguments and unknown opcodes are swallowed without a beat.
// Pipeline: a byte is registered at the input, decoded, and its result is
// registered at the output.
// Throughput: one byte per cycle while m_tready does not stall the output;
// the decode between the input and output registers is combinational.
// Stalls: while m_tready is low and a result waits, the decoded byte holds
// in the input register; s_tready drops only when both registers are full.
// Reset: asynchronous, active low; both stages empty and no command open.
`include "oled_command_decoder_assert.svh"

module oled_command_decoder
    import ocd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] value
    input  logic        s_tuser,    // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [4:0] reg_id, [12:5] reg_value, [15:13] zero
    output logic [1:0]  m_tuser     // [0] is_data, [1] invalid
);

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_value_reg;
    logic        out_valid_reg;
    ocd_result_t out_res_reg;
    ocd_state_t  state_reg;
    ocd_state_t  state_next;
    ocd_result_t dec_res;
    logic        out_ready;
    logic        in_fire;

    assign out_ready = !out_valid_reg || m_tready;
    assign in_fire   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    ocd_decode u_decode (
        .state      (state_reg),
        .cmd        (in_cmd_reg),
        .value      (in_value_reg),
        .result     (dec_res),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_ready)
                out_valid_reg <= in_valid_reg && dec_res.emit;
            if (in_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg   <= s_tuser;
            in_value_reg <= s_tdata;
        end
        if (in_fire && dec_res.emit)
            out_res_reg <= dec_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_res_reg.reg_value, out_res_reg.reg_id};
    assign m_tuser  = {out_res_reg.invalid, out_res_reg.is_data};

    // data beats carry register id zero and are never flagged
    `OCD_ASSERT_IMP(a_data_clean, clk, rst_n, m_tvalid && m_tuser[0],
                    (m_tdata[4:0] == REG_CONTRAST) && !m_tuser[1])
    // only addressing mode, mux ratio and precharge can be invalid
    `OCD_ASSERT_IMP(a_invalid_ids, clk, rst_n, m_tvalid && m_tuser[1],
                    (m_tdata[4:0] == REG_ADDR_MODE) || (m_tdata[4:0] == REG_MUX_RATIO) ||
                    (m_tdata[4:0] == REG_PRECHARGE))
    // an argument position only exists while a command is open
    `OCD_ASSERT_IMP(a_pos_open, clk, rst_n, state_reg.pos != 3'd0,
                    state_reg.opcode != OP_NONE)
    // a byte held behind a stalled result is not overwritten
    `OCD_ASSERT_NXT(a_hold_input, clk, rst_n, in_valid_reg && !out_ready,
                    in_valid_reg && $stable(in_value_reg) && $stable(in_cmd_reg))

endmodule

// ===== tb/tb_oled_command_decoder.sv =====
`timescale 1ns / 1ps

module tb_oled_command_decoder
    import ocd_pkg::*;
();

    // single-byte opcodes and opcode ranges not named in the package
    localparam logic [7:0] OP_COL_LO_BASE   = 8'h00;
    localparam logic [7:0] OP_COL_HI_BASE   = 8'h10;
    localparam logic [7:0] OP_START_LINE    = 8'h40;
    localparam logic [7:0] OP_PAGE_MODE_PG  = 8'hB0;
    localparam logic [7:0] OP_COM_SCAN_BASE = 8'hC0;
    localparam logic [7:0] OP_COM_SCAN_REV  = 8'hC8;
    localparam logic [7:0] OP_ENTIRE_OFF    = 8'hA4;
    localparam logic [7:0] OP_ENTIRE_ON     = 8'hA5;
    localparam logic [7:0] OP_NORMAL        = 8'hA6;
    localparam logic [7:0] OP_INVERSE       = 8'hA7;
    localparam logic [7:0] OP_DISPLAY_OFF   = 8'hAE;
    localparam logic [7:0] OP_DISPLAY_ON    = 8'hAF;
    localparam logic [7:0] OP_SEG_NORMAL    = 8'hA0;
    localparam logic [7:0] OP_SEG_REMAP     = 8'hA1;
    localparam logic [7:0] OP_SCROLL_STOP   = 8'h2E;
    localparam logic [7:0] OP_SCROLL_GO     = 8'h2F;
    localparam logic [7:0] OP_NOP           = 8'hE3;

    localparam int RANDOM_BYTES  = 600;
    localparam int LONG_HOLD_AT  = 150;
    localparam int LONG_HOLD_LEN = 200;
    localparam int IDLE_LIMIT    = 1000;

    typedef struct {
        logic        cmd;
        logic [7:0]  value;
        int unsigned gap;
    } link_byte_t;

    typedef struct packed {
        logic       is_data;
        logic [4:0] reg_id;
        logic [7:0] reg_value;
        logic       invalid;
    } reg_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] value
    logic        s_tuser = 1'b0;    // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [4:0] reg_id, [12:5] reg_value, [15:13] zero
    logic [1:0]  m_tuser;           // [0] is_data, [1] invalid

    link_byte_t  link_bytes[$];
    reg_write_t  writes_due[$];
    logic [7:0]  open_op = OP_NONE;
    logic [2:0]  arg_pos = 3'd0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int unsigned tx_wait = 0;
    int unsigned rx_hold = 0;
    int unsigned writes_seen = 0;
    int unsigned bad_beats = 0;
    int unsigned idle_cycles = 0;
    link_byte_t  tx_cur;
    reg_write_t  beat_got;

    logic [7:0] openers [16] = '{OP_CONTRAST, OP_SCROLL_R, OP_SCROLL_L, OP_VSCROLL_R,
                                 OP_VSCROLL_L, OP_VSCROLL_AREA, OP_ADDR_MODE, OP_COL_ADDR,
                                 OP_PAGE_ADDR, OP_MUX_RATIO, OP_DISP_OFFSET, OP_COM_PINS,
                                 OP_CLK_DIV, OP_PRECHARGE, OP_VCOMH, OP_CHARGE_PUMP};

    oled_command_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign beat_got = {m_tuser[0], m_tdata[4:0], m_tdata[12:5], m_tuser[1]};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int arg_bytes(input logic [7:0] op);
        case (op)
            OP_SCROLL_R, OP_SCROLL_L:                   return 6;
            OP_VSCROLL_R, OP_VSCROLL_L:                 return 5;
            OP_VSCROLL_AREA, OP_COL_ADDR, OP_PAGE_ADDR: return 2;
            OP_CONTRAST, OP_ADDR_MODE, OP_MUX_RATIO, OP_DISP_OFFSET, OP_COM_PINS,
            OP_CLK_DIV, OP_PRECHARGE, OP_VCOMH, OP_CHARGE_PUMP: return 1;
            default:                                    return 0;
        endcase
    endfunction

    function automatic reg_write_t reg_write(input logic [4:0] id, input logic [7:0] val,
                                             input logic bad);
        reg_write_t w;
        w.is_data   = 1'b0;
        w.reg_id    = id;
        w.reg_value = val;
        w.invalid   = bad;
        return w;
    endfunction

    // Advances the decoder state by one byte and queues the register write it causes.
    task automatic decode_byte(input logic cmd, input logic [7:0] v);
        reg_write_t w;
        logic       hit;
        int         pos;
        begin
            w   = reg_write(REG_CONTRAST, 8'h00, 1'b0);
            hit = 1'b1;
            if (!cmd)
            begin
                w.is_data   = 1'b1;
                w.reg_value = v;
            end
            else if (open_op != OP_NONE)
            begin
                pos = int'(arg_pos);
                case (open_op)
                    OP_CONTRAST: w = reg_write(REG_CONTRAST, v, 1'b0);
                    OP_SCROLL_R, OP_SCROLL_L, OP_VSCROLL_R, OP_VSCROLL_L:
                    begin
                        // first byte and, for horizontal scroll, the last two are dummies
                        if (pos == 1)
                            w = reg_write(REG_SCROLL_START, v & 8'h07, 1'b0);
                        else if (pos == 2)
                            w = reg_write(REG_SCROLL_INTVL, v & 8'h07, 1'b0);
                        else if (pos == 3)
                            w = reg_write(REG_SCROLL_END, v & 8'h07, 1'b0);
                        else if (pos == 4 &&
                                 (open_op == OP_VSCROLL_R || open_op == OP_VSCROLL_L))
                            w = reg_write(REG_VSCROLL_OFS, v & 8'h3F, 1'b0);
                        else
                            hit = 1'b0;
                    end
                    OP_VSCROLL_AREA:
                        w = (pos == 0) ? reg_write(REG_FIXED_ROWS, v & 8'h3F, 1'b0)
                                       : reg_write(REG_SCROLL_ROWS, v & 8'h7F, 1'b0);
                    OP_ADDR_MODE:
                        w = reg_write(REG_ADDR_MODE, v & 8'h03, v[1:0] == 2'b11);
                    OP_COL_ADDR:
                        w = reg_write((pos == 0) ? REG_COL_START : REG_COL_END, v & 8'h7F,
                                      1'b0);
                    OP_PAGE_ADDR:
                        w = reg_write((pos == 0) ? REG_PAGE_START : REG_PAGE_END, v & 8'h07,
                                      1'b0);
                    OP_MUX_RATIO:
                        w = reg_write(REG_MUX_RATIO, v & 8'h3F, (v & 8'h3F) < MUX_MIN);
                    OP_DISP_OFFSET: w = reg_write(REG_DISP_OFFSET, v & 8'h3F, 1'b0);
                    OP_COM_PINS:    w = reg_write(REG_COM_PINS, v & 8'h30, 1'b0);
                    OP_CLK_DIV:     w = reg_write(REG_CLK_DIV, v, 1'b0);
                    OP_PRECHARGE:
                        w = reg_write(REG_PRECHARGE, v, v[3:0] == 4'h0 || v[7:4] == 4'h0);
                    OP_VCOMH:       w = reg_write(REG_VCOMH, v & 8'h70, 1'b0);
                    OP_CHARGE_PUMP: w = reg_write(REG_CHARGE_PUMP, v & 8'h04, 1'b0);
                    default:        hit = 1'b0;
                endcase
                pos++;
                if (pos >= arg_bytes(open_op))
                begin
                    open_op = OP_NONE;
                    arg_pos = 3'd0;
                end
                else
                begin
                    arg_pos = pos[2:0];
                end
            end
            else
            begin
                if ((v & 8'hF0) == OP_COL_LO_BASE)
                    w = reg_write(REG_COL_LO, v & 8'h0F, 1'b0);
                else if ((v & 8'hF0) == OP_COL_HI_BASE)
                    w = reg_write(REG_COL_HI, v & 8'h0F, 1'b0);
                else if ((v & 8'hC0) == OP_START_LINE)
                    w = reg_write(REG_START_LINE, v & 8'h3F, 1'b0);
                else if ((v & 8'hF8) == OP_PAGE_MODE_PG)
                    w = reg_write(REG_PAGE_MODE_PG, v & 8'h07, 1'b0);
                else if ((v & 8'hF0) == OP_COM_SCAN_BASE)
                    w = reg_write(REG_COM_SCAN, {7'd0, v[3]}, 1'b0);
                else
                begin
                    case (v)
                        OP_ENTIRE_OFF, OP_ENTIRE_ON:
                            w = reg_write(REG_ENTIRE_ON, {7'd0, v[0]}, 1'b0);
                        OP_NORMAL, OP_INVERSE:
                            w = reg_write(REG_INVERSE, {7'd0, v[0]}, 1'b0);
                        OP_DISPLAY_OFF, OP_DISPLAY_ON:
                            w = reg_write(REG_DISPLAY_ON, {7'd0, v[0]}, 1'b0);
                        OP_SEG_NORMAL, OP_SEG_REMAP:
                            w = reg_write(REG_SEG_REMAP, {7'd0, v[0]}, 1'b0);
                        OP_SCROLL_STOP, OP_SCROLL_GO:
                            w = reg_write(REG_SCROLL_ACT, {7'd0, v[0]}, 1'b0);
                        OP_SCROLL_R:  w = reg_write(REG_SCROLL_KIND, 8'd0, 1'b0);
                        OP_SCROLL_L:  w = reg_write(REG_SCROLL_KIND, 8'd1, 1'b0);
                        OP_VSCROLL_R: w = reg_write(REG_SCROLL_KIND, 8'd2, 1'b0);
                        OP_VSCROLL_L: w = reg_write(REG_SCROLL_KIND, 8'd3, 1'b0);
                        default:      hit = 1'b0;
                    endcase
                end
                if (arg_bytes(v) != 0)
                begin
                    open_op = v;
                    arg_pos = 3'd0;
                end
            end
            if (hit)
                writes_due.push_back(w);
        end
    endtask

    task automatic send(input logic cmd, input logic [7:0] v);
        link_byte_t b;
        begin
            b.cmd   = cmd;
            b.value = v;
            b.gap   = tx_burst ? 0 : $urandom_range(0, 8);
            link_bytes.push_back(b);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tuser, s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait  = tx_wait - 1;
                    s_tvalid <= 1'b0;
                end
                else if (link_bytes.size() != 0)
                begin
                    tx_cur   = link_bytes.pop_front();
                    tx_wait  = tx_cur.gap;
                    s_tvalid <= 1'b1;
                    s_tuser  <= tx_cur.cmd;
                    s_tdata  <= tx_cur.value;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                writes_seen++;
                if (writes_due.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("unexpected beat: is_data=%0b id=%0d val=%02h inv=%0b",
                                 m_tuser[0], m_tdata[4:0], m_tdata[12:5], m_tuser[1]);
                end
                else
                begin
                    if (writes_due[0] !== beat_got)
                    begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display("mismatch: exp is_data=%0b id=%0d val=%02h inv=%0b,",
                                     writes_due[0].is_data, writes_due[0].reg_id,
                                     writes_due[0].reg_value, writes_due[0].invalid,
                                     " got is_data=%0b id=%0d val=%02h inv=%0b",
                                     m_tuser[0], m_tdata[4:0], m_tdata[12:5], m_tuser[1]);
                    end
                    void'(writes_due.pop_front());
                end
                // one long hold-off lets the input side back up
                if (writes_seen == LONG_HOLD_AT)
                    rx_hold = LONG_HOLD_LEN;
                else
                    rx_hold = rx_burst ? 0 : $urandom_range(0, 8);
                if (writes_seen % 50 == 0)
                    rx_burst = ($urandom_range(0, 3) == 0);
            end
            else if (rx_hold > 0)
            begin
                rx_hold = rx_hold - 1;
            end
            m_tready <= (rx_hold == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         r;
        int         n;
        logic [7:0] op;

        // directed: data extremes, invalid entries, data inside an open command
        send(1'b0, 8'h00);
        send(1'b0, 8'hFF);
        send(1'b1, OP_CONTRAST);
        send(1'b1, 8'hFF);
        send(1'b1, OP_ADDR_MODE);
        send(1'b1, 8'h03);
        send(1'b1, OP_MUX_RATIO);
        send(1'b1, 8'h0E);
        send(1'b1, OP_PRECHARGE);
        send(1'b1, 8'hF0);
        send(1'b1, OP_VSCROLL_L);
        send(1'b1, 8'h00);
        send(1'b0, 8'h55);
        send(1'b1, 8'hFF);
        send(1'b1, 8'h3F);
        send(1'b1, 8'h07);
        send(1'b1, 8'hFF);
        send(1'b1, OP_NOP);
        send(1'b1, OP_COM_SCAN_REV);
        send(1'b1, OP_DISPLAY_ON);
        send(1'b1, 8'h1F);
        send(1'b1, OP_SCROLL_L);
        send(1'b1, 8'hAE);
        send(1'b1, 8'h00);

        // random: mostly well-formed commands with random arguments, some noise
        while (link_bytes.size() < RANDOM_BYTES + 24)
        begin
            if ($urandom_range(0, 5) == 0)
                tx_burst = !tx_burst;
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                op = (r < 7) ? openers[4'($urandom_range(0, 15))]
                             : 8'($urandom_range(0, 255));
                send(1'b1, op);
                n = arg_bytes(op);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send(1'b0, 8'($urandom_range(0, 255)));
                    send(1'b1, 8'($urandom_range(0, 255)));
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (link_bytes.size() != 0 || s_tvalid || writes_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (bad_beats == 0 && writes_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ocd_pkg.sv
rtl/ocd_decode.sv
rtl/oled_command_decoder.sv
tb/tb_oled_command_decoder.sv
